// ===== hdl/clb_pkg.sv =====
// package for the cluster light binning block
// holds default store sizes, field widths, operation and status codes, and the box and controller/datapath structs
// no dependencies
package clb_pkg;

	// default sizes of the stores
	localparam int MAX_CLUSTERS_DEF = 8192;
	localparam int SLICES_DEF       = 16;
	localparam int CAPACITY_DEF     = 64;
	localparam int MAX_BOXES_DEF    = 1024;

	// port field widths
	localparam int CFG_W    = 10;
	localparam int FUNC_W   = 3;
	localparam int LIGHT_W  = 16;
	localparam int XY_W     = 9;
	localparam int Z_W      = 4;
	localparam int ADDR_W   = 19;
	localparam int STATUS_W = 2;
	localparam int OFFSET_W = 20;
	localparam int COUNT_W  = 7;
	localparam int TOTAL_W  = 20;
	localparam int OVF_W    = 32;

	// configuration register indexes
	localparam logic REG_CLUSTERS_X = 1'b0;
	localparam logic REG_CLUSTERS_Y = 1'b1;

	typedef enum logic [FUNC_W-1:0] {
		FN_CLEAR        = 3'd0,
		FN_ADD          = 3'd1,
		FN_FINISH       = 3'd2,
		FN_READ_CLUSTER = 3'd3,
		FN_READ_LIST    = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_RANGE      = 2'd2,
		ST_UNFINISHED = 2'd3
	} status_t;

	typedef struct packed {
		logic [LIGHT_W-1:0] light;
		logic [XY_W-1:0]    x0;
		logic [XY_W-1:0]    x1;
		logic [XY_W-1:0]    y0;
		logic [XY_W-1:0]    y1;
		logic [Z_W-1:0]     z0;
		logic [Z_W-1:0]     z1;
	} box_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic dec;
		logic clr_begin;
		logic clr_step;
		logic box_save;
		logic base1;
		logic base2;
		logic walk_rd;
		logic walk_wr;
		logic scan_begin;
		logic scan_step;
		logic scan_end;
		logic box_rd;
		logic box_ld;
		logic set_fin;
		logic resp;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              box_full;
		logic              sweep_done;
		logic              cell_ok;
		logic              fill_mode;
		logic              scan_done;
		logic              replay_done;
	} stat_t;

endpackage

// ===== hdl/cluster_light_binning_top.sv =====
// cluster light binning: count lights per cluster, prefix offsets, fill the light list
// add stores the box and counts it in each covered cell; read returns a cluster or list entry; clear
// zeroes the counts; finish runs the prefix scan, then replays each kept box; one item at a time
// done pulses one cycle with the result; the receiver cannot stall it
// after reset busy stays high during a pass that zeroes the counts
// uses clb_pkg, clb_ctrl, clb_dp
module cluster_light_binning_top #(
	parameter int MAX_CLUSTERS     = clb_pkg::MAX_CLUSTERS_DEF,
	parameter int SLICES           = clb_pkg::SLICES_DEF,
	parameter int CLUSTER_CAPACITY = clb_pkg::CAPACITY_DEF,
	parameter int MAX_BOXES        = clb_pkg::MAX_BOXES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// command side
	input  logic                         start,
	output logic                         busy,
	input  logic [clb_pkg::FUNC_W-1:0]   func,
	input  logic [clb_pkg::LIGHT_W-1:0]  light_index,
	input  logic [clb_pkg::XY_W-1:0]     min_x,
	input  logic [clb_pkg::XY_W-1:0]     max_x,
	input  logic [clb_pkg::XY_W-1:0]     min_y,
	input  logic [clb_pkg::XY_W-1:0]     max_y,
	input  logic [clb_pkg::Z_W-1:0]      min_z,
	input  logic [clb_pkg::Z_W-1:0]      max_z,
	input  logic [clb_pkg::ADDR_W-1:0]   address,
	// configuration write beat
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [clb_pkg::CFG_W-1:0]    cfg_data,
	// result beat
	output logic                         done,
	output logic [clb_pkg::STATUS_W-1:0] status,
	output logic [clb_pkg::OFFSET_W-1:0] entry_offset,
	output logic [clb_pkg::COUNT_W-1:0]  entry_count,
	output logic [clb_pkg::LIGHT_W-1:0]  list_light,
	output logic [clb_pkg::TOTAL_W-1:0]  total_references,
	output logic [clb_pkg::COUNT_W-1:0]  largest_count,
	output logic [clb_pkg::OVF_W-1:0]    overflow_total
);
	import clb_pkg::*;

	// commands down, status up
	cmd_t  cmd;
	stat_t st;

	// sequencer: decode, clearing pass, cell walk, prefix scan, box replay
	clb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .st(st), .cmd(cmd)
	);

	// stores, grid arithmetic and result registers
	clb_dp #(
		.MAX_CLUSTERS(MAX_CLUSTERS), .SLICES(SLICES),
		.CLUSTER_CAPACITY(CLUSTER_CAPACITY), .MAX_BOXES(MAX_BOXES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.func(func), .light_index(light_index), .min_x(min_x), .max_x(max_x),
		.min_y(min_y), .max_y(max_y), .min_z(min_z), .max_z(max_z), .address(address),
		.done(done), .status(status), .entry_offset(entry_offset),
		.entry_count(entry_count), .list_light(list_light),
		.total_references(total_references), .largest_count(largest_count),
		.overflow_total(overflow_total)
	);

endmodule

// ===== hdl/clb_ram.sv =====
// generic simple dual-port ram with registered read
// one write port, one read port with read enable; no dependencies
module clb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/clb_ctrl.sv =====
// controller state machine of the cluster light binning block
// sequences clear, add, finish and read operations; uses clb_pkg
module clb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  clb_pkg::stat_t st,
	output clb_pkg::cmd_t  cmd
);
	import clb_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_INIT  = 12'b000000000010,
		S_DEC   = 12'b000000000100,
		S_CLR   = 12'b000000001000,
		S_BASE1 = 12'b000000010000,
		S_BASE2 = 12'b000000100000,
		S_WRD   = 12'b000001000000,
		S_WWR   = 12'b000010000000,
		S_SCAN  = 12'b000100000000,
		S_BRD   = 12'b001000000000,
		S_BLD   = 12'b010000000000,
		S_RESP  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_in = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_INIT: begin
				if (st.sweep_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				case (st.func)
					FN_CLEAR: begin
						cmd.clr_begin = 1'b1;
						state_d       = S_CLR;
					end
					FN_ADD: begin
						if (st.box_full) begin
							state_d = S_RESP;
						end else begin
							cmd.box_save = 1'b1;
							state_d      = S_BASE1;
						end
					end
					FN_FINISH: begin
						cmd.scan_begin = 1'b1;
						state_d        = S_SCAN;
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_CLR: begin
				if (st.sweep_done) begin
					state_d = S_RESP;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			S_BASE1: begin
				cmd.base1 = 1'b1;
				state_d   = S_BASE2;
			end
			S_BASE2: begin
				cmd.base2 = 1'b1;
				state_d   = S_WRD;
			end
			S_WRD: begin
				if (st.cell_ok) begin
					cmd.walk_rd = 1'b1;
					state_d     = S_WWR;
				end else if (st.fill_mode) begin
					state_d = S_BRD;
				end else begin
					state_d = S_RESP;
				end
			end
			S_WWR: begin
				cmd.walk_wr = 1'b1;
				state_d     = S_WRD;
			end
			S_SCAN: begin
				if (st.scan_done) begin
					cmd.scan_end = 1'b1;
					state_d      = S_BRD;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_BRD: begin
				if (st.replay_done) begin
					cmd.set_fin = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.box_rd = 1'b1;
					state_d    = S_BLD;
				end
			end
			S_BLD: begin
				cmd.box_ld = 1'b1;
				state_d    = S_BASE1;
			end
			S_RESP: begin
				cmd.resp = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/clb_dp.sv =====
// datapath of the cluster light binning block: config, stores, cell walker, prefix scan
// driven by clb_ctrl commands; uses clb_pkg and clb_ram
module clb_dp #(
	parameter int MAX_CLUSTERS     = clb_pkg::MAX_CLUSTERS_DEF,
	parameter int SLICES           = clb_pkg::SLICES_DEF,
	parameter int CLUSTER_CAPACITY = clb_pkg::CAPACITY_DEF,
	parameter int MAX_BOXES        = clb_pkg::MAX_BOXES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  clb_pkg::cmd_t                  cmd,
	output clb_pkg::stat_t                 st,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [clb_pkg::CFG_W-1:0]      cfg_data,
	input  logic [clb_pkg::FUNC_W-1:0]     func,
	input  logic [clb_pkg::LIGHT_W-1:0]    light_index,
	input  logic [clb_pkg::XY_W-1:0]       min_x,
	input  logic [clb_pkg::XY_W-1:0]       max_x,
	input  logic [clb_pkg::XY_W-1:0]       min_y,
	input  logic [clb_pkg::XY_W-1:0]       max_y,
	input  logic [clb_pkg::Z_W-1:0]        min_z,
	input  logic [clb_pkg::Z_W-1:0]        max_z,
	input  logic [clb_pkg::ADDR_W-1:0]     address,
	output logic                           done,
	output logic [clb_pkg::STATUS_W-1:0]   status,
	output logic [clb_pkg::OFFSET_W-1:0]   entry_offset,
	output logic [clb_pkg::COUNT_W-1:0]    entry_count,
	output logic [clb_pkg::LIGHT_W-1:0]    list_light,
	output logic [clb_pkg::TOTAL_W-1:0]    total_references,
	output logic [clb_pkg::COUNT_W-1:0]    largest_count,
	output logic [clb_pkg::OVF_W-1:0]      overflow_total
);
	import clb_pkg::*;

	localparam int CL_W       = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int CLI_W      = $clog2(MAX_CLUSTERS + 1);
	localparam int CNT_W      = $clog2(CLUSTER_CAPACITY + 1);
	localparam int LIST_DEPTH = MAX_CLUSTERS * CLUSTER_CAPACITY;
	localparam int LA_W       = $clog2(LIST_DEPTH);
	localparam int SUM_W      = $clog2(LIST_DEPTH + 1);
	localparam int END_W      = SUM_W + 1;
	localparam int BOX_AW     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int BT_W       = $clog2(MAX_BOXES + 1);
	localparam int PL_W       = 2 * CFG_W;
	localparam int GP_W       = PL_W + $clog2(SLICES + 1);
	localparam int IDX_W      = GP_W;
	localparam int ZLAST      = (SLICES - 1 > 15) ? 15 : SLICES - 1;
	localparam logic [Z_W-1:0] Z_LAST = Z_W'(ZLAST);

	// configuration and grid size
	logic [CFG_W-1:0] cx_q, cy_q;
	logic [PL_W-1:0]  plane_q, plane_c;
	logic [GP_W-1:0]  gp_c;
	logic [CLI_W-1:0] grid_q;

	// captured item
	logic [FUNC_W-1:0]  func_q;
	logic [LIGHT_W-1:0] light_q;
	logic [XY_W-1:0]    minx_q, maxx_q, miny_q, maxy_q;
	logic [Z_W-1:0]     minz_q, maxz_q;
	logic [ADDR_W-1:0]  addr_q;

	// box under walk
	box_t               in_box, raw_box, box_rdata;
	logic [CFG_W-1:0]   cxm1, cym1;
	logic [XY_W-1:0]    x0c, x1c, y0c, y1c;
	logic [Z_W-1:0]     z0c, z1c;
	logic [LIGHT_W-1:0] bl_q;
	logic [XY_W-1:0]    x0_q, x1_q, y0_q, y1_q, x_q, y_q;
	logic [Z_W-1:0]     z0_q, z1_q, z_q;
	logic [IDX_W-1:0]   idx_q, row_q, slice_q, cy0_q;
	logic [18:0]        cy0_c;
	logic [23:0]        slice_c;
	logic [IDX_W-1:0]   first_c;
	logic               empty_q, cell_ok_q, fill_q;

	// walk step
	logic [XY_W-1:0]  nx, ny;
	logic [Z_W-1:0]   nz;
	logic [IDX_W-1:0] nidx, nrow, nslice;
	logic             nlast;

	// frame state
	logic [BT_W-1:0]  box_total_q, rp_q;
	logic [OVF_W-1:0] dropped_q;
	logic [SUM_W-1:0] ref_q, sum_q;
	logic [CNT_W-1:0] peak_q, pmax_q;
	logic             fin_q;
	logic [CLI_W-1:0] sweep_q, scan_i_q;
	logic             pend_q;
	logic [CL_W-1:0]  pend_idx_q;
	status_t          stat_q, stat_c;

	// ram ports
	logic             cnt_we, cnt_re;
	logic [CL_W-1:0]  cnt_waddr, cnt_raddr;
	logic [CNT_W-1:0] cnt_wdata, cnt_rd;
	logic             start_re;
	logic [CL_W-1:0]  start_raddr;
	logic [SUM_W-1:0] start_rd;
	logic             cur_we;
	logic [CL_W-1:0]  cur_waddr;
	logic [SUM_W-1:0] cur_wdata, cur_rd;
	logic [LIGHT_W-1:0] list_rd;
	logic [END_W-1:0] fill_end;
	logic             fill_go, cnt_go, clr_w, scan_rd;

	assign cfg_ready = 1'b1;

	assign plane_c = cx_q * cy_q;
	assign gp_c    = GP_W'(plane_c) * GP_W'(SLICES);

	// box fields with clamping to the grid
	always_comb begin
		in_box.light = light_q;
		in_box.x0    = minx_q;
		in_box.x1    = maxx_q;
		in_box.y0    = miny_q;
		in_box.y1    = maxy_q;
		in_box.z0    = minz_q;
		in_box.z1    = maxz_q;
		raw_box      = cmd.box_ld ? box_rdata : in_box;
		cxm1         = cx_q - CFG_W'(1);
		cym1         = cy_q - CFG_W'(1);
		x0c = ({1'b0, raw_box.x0} > cxm1) ? cxm1[XY_W-1:0] : raw_box.x0;
		x1c = ({1'b0, raw_box.x1} > cxm1) ? cxm1[XY_W-1:0] : raw_box.x1;
		y0c = ({1'b0, raw_box.y0} > cym1) ? cym1[XY_W-1:0] : raw_box.y0;
		y1c = ({1'b0, raw_box.y1} > cym1) ? cym1[XY_W-1:0] : raw_box.y1;
		z0c = (raw_box.z0 > Z_LAST) ? Z_LAST : raw_box.z0;
		z1c = (raw_box.z1 > Z_LAST) ? Z_LAST : raw_box.z1;
	end

	assign cy0_c   = cx_q * y0_q;
	assign slice_c = plane_q * z0_q;
	assign first_c = slice_q + cy0_q + IDX_W'(x0_q);

	// next cell in x, then y, then z order
	always_comb begin
		nx     = x_q;
		ny     = y_q;
		nz     = z_q;
		nrow   = row_q;
		nslice = slice_q;
		nidx   = idx_q;
		nlast  = 1'b0;
		if (x_q < x1_q) begin
			nx   = x_q + XY_W'(1);
			nidx = idx_q + IDX_W'(1);
		end else if (y_q < y1_q) begin
			ny   = y_q + XY_W'(1);
			nx   = x0_q;
			nrow = row_q + IDX_W'(cx_q);
			nidx = row_q + IDX_W'(cx_q) + IDX_W'(x0_q);
		end else if (z_q < z1_q) begin
			nz     = z_q + Z_W'(1);
			ny     = y0_q;
			nx     = x0_q;
			nslice = slice_q + IDX_W'(plane_q);
			nrow   = slice_q + IDX_W'(plane_q) + cy0_q;
			nidx   = slice_q + IDX_W'(plane_q) + cy0_q + IDX_W'(x0_q);
		end else begin
			nlast = 1'b1;
		end
	end

	// status of the operation, formed at decode
	always_comb begin
		case (func_q)
			FN_ADD: begin
				stat_c = (box_total_q >= BT_W'(MAX_BOXES)) ? ST_FULL : ST_OK;
			end
			FN_READ_CLUSTER: begin
				if (!fin_q) begin
					stat_c = ST_UNFINISHED;
				end else if (32'(addr_q) >= 32'(grid_q)) begin
					stat_c = ST_RANGE;
				end else begin
					stat_c = ST_OK;
				end
			end
			FN_READ_LIST: begin
				if (!fin_q) begin
					stat_c = ST_UNFINISHED;
				end else if (32'(addr_q) >= 32'(ref_q) || 32'(addr_q) >= 32'(LIST_DEPTH)) begin
					stat_c = ST_RANGE;
				end else begin
					stat_c = ST_OK;
				end
			end
			default: begin
				stat_c = ST_OK;
			end
		endcase
	end

	// ram port selection
	assign clr_w    = cmd.clr_step && (sweep_q != CLI_W'(MAX_CLUSTERS));
	assign cnt_go   = cmd.walk_wr && !fill_q && (cnt_rd < CNT_W'(CLUSTER_CAPACITY));
	assign fill_end = END_W'(start_rd) + END_W'(cnt_rd);
	assign fill_go  = cmd.walk_wr && fill_q && (END_W'(cur_rd) < fill_end)
		&& (32'(cur_rd) < 32'(LIST_DEPTH));
	assign scan_rd  = cmd.scan_step && (scan_i_q < grid_q);

	always_comb begin
		cnt_we    = clr_w || cnt_go;
		cnt_waddr = clr_w ? sweep_q[CL_W-1:0] : idx_q[CL_W-1:0];
		cnt_wdata = clr_w ? '0 : cnt_rd + CNT_W'(1);
		cnt_re    = cmd.dec || cmd.walk_rd || scan_rd;
		if (cmd.dec) begin
			cnt_raddr = CL_W'(addr_q);
		end else if (cmd.walk_rd) begin
			cnt_raddr = idx_q[CL_W-1:0];
		end else begin
			cnt_raddr = scan_i_q[CL_W-1:0];
		end
		start_re    = cmd.dec || cmd.walk_rd;
		start_raddr = cmd.dec ? CL_W'(addr_q) : idx_q[CL_W-1:0];
		cur_we      = (cmd.scan_step && pend_q) || fill_go;
		cur_waddr   = fill_go ? idx_q[CL_W-1:0] : pend_idx_q;
		cur_wdata   = fill_go ? cur_rd + SUM_W'(1) : sum_q;
	end

	clb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CLUSTERS)) u_counts (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rd)
	);

	clb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CLUSTERS)) u_starts (
		.clk(clk), .we(cmd.scan_step && pend_q), .waddr(pend_idx_q), .wdata(sum_q),
		.re(start_re), .raddr(start_raddr), .rdata(start_rd)
	);

	clb_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CLUSTERS)) u_cursors (
		.clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
		.re(cmd.walk_rd), .raddr(idx_q[CL_W-1:0]), .rdata(cur_rd)
	);

	clb_ram #(.WIDTH(LIGHT_W), .DEPTH(LIST_DEPTH)) u_list (
		.clk(clk), .we(fill_go), .waddr(cur_rd[LA_W-1:0]), .wdata(bl_q),
		.re(cmd.dec), .raddr(LA_W'(addr_q)), .rdata(list_rd)
	);

	clb_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_BOXES)) u_boxes (
		.clk(clk), .we(cmd.box_save), .waddr(box_total_q[BOX_AW-1:0]), .wdata(in_box),
		.re(cmd.box_rd), .raddr(rp_q[BOX_AW-1:0]), .rdata(box_rdata)
	);

	// status to the controller
	always_comb begin
		st.func        = func_q;
		st.box_full    = (box_total_q >= BT_W'(MAX_BOXES));
		st.sweep_done  = (sweep_q == CLI_W'(MAX_CLUSTERS));
		st.cell_ok     = cell_ok_q;
		st.fill_mode   = fill_q;
		st.scan_done   = !pend_q && (scan_i_q >= grid_q);
		st.replay_done = (rp_q >= box_total_q);
	end

	// control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q        <= CFG_W'(1);
			cy_q        <= CFG_W'(1);
			plane_q     <= PL_W'(1);
			grid_q      <= CLI_W'((SLICES > MAX_CLUSTERS) ? MAX_CLUSTERS : SLICES);
			box_total_q <= '0;
			rp_q        <= '0;
			dropped_q   <= '0;
			ref_q       <= '0;
			peak_q      <= '0;
			fin_q       <= 1'b0;
			sweep_q     <= '0;
			scan_i_q    <= '0;
			pend_q      <= 1'b0;
			fill_q      <= 1'b0;
			cell_ok_q   <= 1'b0;
			done        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_CLUSTERS_X) begin
					cx_q <= cfg_data;
				end else begin
					cy_q <= cfg_data;
				end
			end
			plane_q <= plane_c;
			grid_q  <= (gp_c >= GP_W'(MAX_CLUSTERS)) ? CLI_W'(MAX_CLUSTERS) : CLI_W'(gp_c);
			done    <= cmd.resp;
			if (cmd.clr_begin) begin
				sweep_q     <= '0;
				box_total_q <= '0;
				dropped_q   <= '0;
				ref_q       <= '0;
				peak_q      <= '0;
				fin_q       <= 1'b0;
			end
			if (clr_w) begin
				sweep_q <= sweep_q + CLI_W'(1);
			end
			if (cmd.box_save) begin
				box_total_q <= box_total_q + BT_W'(1);
				fin_q       <= 1'b0;
				fill_q      <= 1'b0;
			end
			if (cmd.box_ld) begin
				rp_q   <= rp_q + BT_W'(1);
				fill_q <= 1'b1;
			end
			if (cmd.base2) begin
				cell_ok_q <= !empty_q && (32'(first_c) < 32'(grid_q));
			end
			if (cmd.walk_wr) begin
				cell_ok_q <= !nlast && (32'(nidx) < 32'(grid_q));
				if (!fill_q && !cnt_go && (dropped_q != '1)) begin
					dropped_q <= dropped_q + OVF_W'(1);
				end
			end
			if (cmd.scan_begin) begin
				scan_i_q <= '0;
				pend_q   <= 1'b0;
			end
			if (cmd.scan_step) begin
				pend_q <= scan_rd;
				if (scan_rd) begin
					scan_i_q <= scan_i_q + CLI_W'(1);
				end
			end
			if (cmd.scan_end) begin
				ref_q  <= sum_q;
				peak_q <= pmax_q;
				rp_q   <= '0;
			end
			if (cmd.set_fin) begin
				fin_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q  <= func;
			light_q <= light_index;
			minx_q  <= min_x;
			maxx_q  <= max_x;
			miny_q  <= min_y;
			maxy_q  <= max_y;
			minz_q  <= min_z;
			maxz_q  <= max_z;
			addr_q  <= address;
		end
		if (cmd.dec) begin
			stat_q <= stat_c;
		end
		if (cmd.box_save || cmd.box_ld) begin
			bl_q <= raw_box.light;
			x0_q <= x0c;
			x1_q <= x1c;
			y0_q <= y0c;
			y1_q <= y1c;
			z0_q <= z0c;
			z1_q <= z1c;
		end
		if (cmd.base1) begin
			cy0_q   <= IDX_W'(cy0_c);
			slice_q <= IDX_W'(slice_c);
			x_q     <= x0_q;
			y_q     <= y0_q;
			z_q     <= z0_q;
			empty_q <= (cx_q == '0) || (cy_q == '0) || (x0_q > x1_q) || (y0_q > y1_q)
				|| (z0_q > z1_q);
		end
		if (cmd.base2) begin
			row_q <= slice_q + cy0_q;
			idx_q <= first_c;
		end
		if (cmd.walk_wr) begin
			x_q     <= nx;
			y_q     <= ny;
			z_q     <= nz;
			row_q   <= nrow;
			slice_q <= nslice;
			idx_q   <= nidx;
		end
		if (cmd.scan_begin) begin
			sum_q  <= '0;
			pmax_q <= '0;
		end
		if (cmd.scan_step) begin
			if (pend_q) begin
				sum_q <= sum_q + SUM_W'(cnt_rd);
				if (cnt_rd > pmax_q) begin
					pmax_q <= cnt_rd;
				end
			end
			if (scan_rd) begin
				pend_idx_q <= scan_i_q[CL_W-1:0];
			end
		end
		if (cmd.resp) begin
			status <= stat_q;
			entry_offset <= ((func_q == FN_READ_CLUSTER) && (stat_q == ST_OK))
				? OFFSET_W'(start_rd) : '0;
			entry_count <= ((func_q == FN_READ_CLUSTER) && (stat_q == ST_OK))
				? COUNT_W'(cnt_rd) : '0;
			list_light <= ((func_q == FN_READ_LIST) && (stat_q == ST_OK)) ? list_rd : '0;
			total_references <= fin_q ? TOTAL_W'(ref_q) : '0;
			largest_count    <= fin_q ? COUNT_W'(peak_q) : '0;
			overflow_total   <= dropped_q;
		end
	end

endmodule
